>>> hw/rtl/lflt_pkg.sv
// Shared constants, codes and types of the login failure lockout table.
package lflt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    localparam int KEY_W     = 64;
    localparam int TIME_W    = 48;
    localparam int CNT_W     = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int RETRY_W   = 13;
    localparam int DIV_W     = 33;

    // whole seconds: (x >> 6) * ceil(2^41 / 15625) >> 41 for x below 2^33
    localparam int US_SHIFT    = 6;
    localparam int SHR_W       = DIV_W - US_SHIFT;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = 41;
    localparam int PROD_W      = SHR_W + RECIP_W;

    localparam logic [RECIP_W-1:0] US_RECIP   = RECIP_W'(140737489);
    localparam logic [DIV_W-1:0]   US_PER_SEC = DIV_W'(1000000);
    localparam logic [RETRY_W-1:0] RETRY_MAX      = RETRY_W'(4294);
    localparam logic [TIME_W-1:0]  RETRY_LIMIT_US = TIME_W'(64'd4295000000);
    localparam logic [CNT_W-1:0]   CNT_MAX        = '1;

    localparam logic [CNT_W-1:0] MAX_FAIL_RST  = CNT_W'(5);
    localparam logic [CFG_W-1:0] LOCK_TIME_RST = CFG_W'(300000000);
    localparam logic [CFG_W-1:0] WINDOW_RST    = CFG_W'(900000000);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAIL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TIME = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = CFG_IDX_W'(2);

    localparam logic [1:0] OUTC_INVALID = 2'd0;
    localparam logic [1:0] OUTC_VALID   = 2'd1;

    localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
    localparam logic [1:0] VERDICT_REJECTED = 2'd1;
    localparam logic [1:0] VERDICT_LOCKED   = 2'd2;
    localparam logic [1:0] VERDICT_PENDING  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] win_start;
        logic [TIME_W-1:0] lock_until;
    } entry_t;

endpackage

>>> hw/rtl/lflt_ifs.sv
// Valid/ready channel interfaces for login attempts and their verdicts.
interface lflt_in_if import lflt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  user_key;
    logic [TIME_W-1:0] now_time_us;
    logic [1:0]        credential_outcome;

    modport source (output valid, user_key, now_time_us, credential_outcome, input ready);
    modport sink   (input valid, user_key, now_time_us, credential_outcome, output ready);
endinterface

interface lflt_out_if import lflt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         verdict;
    logic [RETRY_W-1:0] retry_seconds;
    logic               tracked;
    logic               lock_started;

    modport source (output valid, verdict, retry_seconds, tracked, lock_started, input ready);
    modport sink   (input valid, verdict, retry_seconds, tracked, lock_started, output ready);
endinterface

>>> hw/rtl/lflt_mem.sv
// Entry memory: one write port, one registered read port.
module lflt_mem import lflt_pkg::*; (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/lflt_div.sv
// Reciprocal multiply that turns remaining microseconds into whole seconds.
module lflt_div import lflt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    output logic               done,
    output logic [RETRY_W-1:0] quotient
);

    logic               done_reg, done_next;
    logic [RETRY_W-1:0] quo_reg, quo_next;
    logic [SHR_W-1:0]   shr;
    logic [PROD_W-1:0]  prod;

    // drop the factor 64, then divide by 15625 with multiply and shift
    assign shr  = dividend[DIV_W-1:US_SHIFT];
    assign prod = PROD_W'(shr) * PROD_W'(US_RECIP);

    always_comb
    begin
        done_next = start;
        quo_next  = quo_reg;
        if (start)
        begin
            quo_next = prod[RECIP_SHIFT +: RETRY_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/login_failure_lockout_table.sv
// Top level of the login failure lockout table: sequencer, shared subtractor and registers.
// One login attempt is taken at a time; ready stays low until its result is loaded into
// the output register. The key memory is scanned one entry per cycle, and the scan stops
// early when the key is found; a locked entry goes through the reciprocal multiply that
// yields the whole seconds left, except when the wait is clamped at 4294 seconds.
// The next attempt may be taken while a result waits.
module login_failure_lockout_table import lflt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    lflt_in_if.sink              in_item,
    lflt_out_if.source           out_item,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_CHK_LOCK = 7'b0000100,
        S_CHK_WIN  = 7'b0001000,
        S_UPDATE   = 7'b0010000,
        S_DIV      = 7'b0100000,
        S_WRITE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] max_fail_reg;
    logic [CFG_W-1:0] lock_time_reg;
    logic [CFG_W-1:0] window_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic                     free_found_reg, free_found_next;
    logic                     out_valid_reg, out_valid_next;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [1:0]         outc_reg, outc_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               tracked_reg, tracked_next;
    entry_t             cur_reg, cur_next;
    logic [TIME_W-1:0]  diff_reg, diff_next;
    logic               locked_reg, locked_next;
    logic               restart_reg, restart_next;
    logic [1:0]         verdict_reg, verdict_next;
    logic               started_reg, started_next;
    logic [RETRY_W-1:0] retry_reg, retry_next;

    logic [1:0]         out_verdict_reg, out_verdict_next;
    logic [RETRY_W-1:0] out_retry_reg, out_retry_next;
    logic               out_tracked_reg, out_tracked_next;
    logic               out_started_reg, out_started_next;

    entry_t             rd_data;
    logic               mem_we;
    logic               div_start;
    logic               div_done;
    logic [RETRY_W-1:0] div_quo;

    logic [TIME_W-1:0]  sub_a, sub_b;
    logic [TIME_W:0]    sub_res;
    logic [TIME_W:0]    lock_sum;
    logic [TIME_W-1:0]  lock_end;
    logic [CNT_W-1:0]   cnt_base, cnt_inc;
    logic [TIME_W-1:0]  ws_base;
    logic               cmp_bit, hit, free_now, out_free, accept;

    lflt_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (idx_reg),
        .wr_data (cur_reg),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    lflt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_reg[DIV_W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_item.ready = (state_reg == S_IDLE);
    assign accept        = in_item.valid && in_item.ready;
    assign out_free      = !out_valid_reg || out_item.ready;

    assign cmp_bit  = valid_reg[cmp_idx_reg];
    assign hit      = cmp_vld_reg && cmp_bit && (rd_data.key == key_reg);
    assign free_now = cmp_vld_reg && !cmp_bit;

    // shared subtractor: lock end minus now, then now minus window start
    assign sub_a   = (state_reg == S_CHK_LOCK) ? cur_reg.lock_until : now_reg;
    assign sub_b   = (state_reg == S_CHK_LOCK) ? now_reg : cur_reg.win_start;
    assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};

    assign lock_sum = {1'b0, now_reg} + (TIME_W + 1)'(lock_time_reg);
    assign lock_end = lock_sum[TIME_W] ? '1 : lock_sum[TIME_W-1:0];
    assign cnt_base = restart_reg ? '0 : cur_reg.cnt;
    assign cnt_inc  = (cnt_base == CNT_MAX) ? CNT_MAX : cnt_base + CNT_W'(1);
    assign ws_base  = restart_reg ? now_reg : cur_reg.win_start;

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        cmp_vld_next     = cmp_vld_reg;
        free_found_next  = free_found_reg;
        out_valid_next   = out_valid_reg && !out_item.ready;
        key_next         = key_reg;
        now_next         = now_reg;
        outc_next        = outc_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        free_idx_next    = free_idx_reg;
        idx_next         = idx_reg;
        tracked_next     = tracked_reg;
        cur_next         = cur_reg;
        diff_next        = diff_reg;
        locked_next      = locked_reg;
        restart_next     = restart_reg;
        verdict_next     = verdict_reg;
        started_next     = started_reg;
        retry_next       = retry_reg;
        out_verdict_next = out_verdict_reg;
        out_retry_next   = out_retry_reg;
        out_tracked_next = out_tracked_reg;
        out_started_next = out_started_reg;
        mem_we           = 1'b0;
        div_start        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next        = in_item.user_key;
                    now_next        = in_item.now_time_us;
                    outc_next       = in_item.credential_outcome;
                    scan_idx_next   = '0;
                    cmp_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                scan_idx_next = (scan_idx_reg == IDX_LAST) ? scan_idx_reg
                                                           : scan_idx_reg + IDX_W'(1);
                if (free_now && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (hit)
                begin
                    idx_next     = cmp_idx_reg;
                    cur_next     = rd_data;
                    tracked_next = 1'b1;
                    state_next   = S_CHK_LOCK;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == IDX_LAST))
                begin
                    // miss: take the lowest free entry
                    tracked_next = free_found_reg || free_now;
                    idx_next     = free_found_reg ? free_idx_reg : cmp_idx_reg;
                    cur_next     = '{key: key_reg, cnt: '0, win_start: '0, lock_until: '0};
                    state_next   = S_CHK_LOCK;
                end
            end
            S_CHK_LOCK:
            begin
                diff_next   = sub_res[TIME_W-1:0];
                locked_next = tracked_reg && !sub_res[TIME_W] && (sub_res[TIME_W-1:0] != '0);
                state_next  = S_CHK_WIN;
            end
            S_CHK_WIN:
            begin
                restart_next = (cur_reg.win_start == '0) ||
                               (!sub_res[TIME_W] &&
                                (sub_res[TIME_W-1:0] > TIME_W'(window_reg)));
                state_next   = S_UPDATE;
            end
            S_UPDATE:
            begin
                started_next = 1'b0;
                retry_next   = '0;
                state_next   = S_WRITE;
                if (locked_reg)
                begin
                    verdict_next = VERDICT_LOCKED;
                    if (diff_reg >= RETRY_LIMIT_US)
                    begin
                        retry_next = RETRY_MAX;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else if (outc_reg == OUTC_INVALID)
                begin
                    verdict_next       = VERDICT_REJECTED;
                    cur_next.cnt       = cnt_inc;
                    cur_next.win_start = ws_base;
                    if (cnt_inc >= max_fail_reg)
                    begin
                        cur_next.cnt        = '0;
                        cur_next.win_start  = now_reg;
                        cur_next.lock_until = lock_end;
                        started_next        = tracked_reg;
                    end
                end
                else if (outc_reg == OUTC_VALID)
                begin
                    verdict_next        = VERDICT_ACCEPTED;
                    cur_next.cnt        = '0;
                    cur_next.win_start  = now_reg;
                    cur_next.lock_until = '0;
                end
                else
                begin
                    verdict_next = VERDICT_PENDING;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    retry_next = div_quo;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    mem_we = tracked_reg;
                    if (tracked_reg)
                    begin
                        valid_next[idx_reg] = 1'b1;
                    end
                    out_valid_next   = 1'b1;
                    out_verdict_next = verdict_reg;
                    out_retry_next   = retry_reg;
                    out_tracked_next = tracked_reg;
                    out_started_next = started_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_fail_reg   <= MAX_FAIL_RST;
            lock_time_reg  <= LOCK_TIME_RST;
            window_reg     <= WINDOW_RST;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MAX_FAIL:  max_fail_reg  <= cfg_data[CNT_W-1:0];
                    CFG_LOCK_TIME: lock_time_reg <= cfg_data;
                    CFG_WINDOW:    window_reg    <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        now_reg         <= now_next;
        outc_reg        <= outc_next;
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        free_idx_reg    <= free_idx_next;
        idx_reg         <= idx_next;
        tracked_reg     <= tracked_next;
        cur_reg         <= cur_next;
        diff_reg        <= diff_next;
        locked_reg      <= locked_next;
        restart_reg     <= restart_next;
        verdict_reg     <= verdict_next;
        started_reg     <= started_next;
        retry_reg       <= retry_next;
        out_verdict_reg <= out_verdict_next;
        out_retry_reg   <= out_retry_next;
        out_tracked_reg <= out_tracked_next;
        out_started_reg <= out_started_next;
    end

    assign out_item.valid         = out_valid_reg;
    assign out_item.verdict       = out_verdict_reg;
    assign out_item.retry_seconds = out_retry_reg;
    assign out_item.tracked       = out_tracked_reg;
    assign out_item.lock_started  = out_started_reg;

endmodule
